// ===== src/lfca_pkg.sv =====
package lfca_pkg;

   localparam int STATE_W = 48;
   localparam int AUX_W   = 32;
   localparam int ROUNDS  = 32;
   localparam int CELLS   = 2 * ROUNDS;

   localparam logic [15:0]        TABLE_A = 16'h2C79;
   localparam logic [15:0]        TABLE_B = 16'h6671;
   localparam logic [31:0]        TABLE_C = 32'h7907287B;
   localparam logic [STATE_W-1:0] FB_TAPS = 48'hB380_8322_0073;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [AUX_W-1:0]   aux;
   } round_word_type;

   function automatic logic filter_bit(input logic [STATE_W-1:0] s);
      logic [4:0] g;
      g[0] = TABLE_A[{s[41], s[42], s[44], s[45]}];
      g[1] = TABLE_B[{s[32], s[33], s[35], s[39]}];
      g[2] = TABLE_B[{s[21], s[24], s[26], s[30]}];
      g[3] = TABLE_B[{s[14], s[16], s[18], s[19]}];
      g[4] = TABLE_A[{s[1], s[3], s[4], s[13]}];
      return TABLE_C[g];
   endfunction

   function automatic logic parity_bit(input logic [STATE_W-1:0] s);
      return ^(s & FB_TAPS);
   endfunction

endpackage

// ===== src/lfca_cell.sv =====
module lfca_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    init_mode,
   input  logic                    key_bit,
   input  logic                    valid_in,
   input  lfca_pkg::round_word_type word_in,
   output logic                    valid_out,
   output lfca_pkg::round_word_type word_out
);
   import lfca_pkg::*;

   logic           valid_ff;
   round_word_type word_ff;
   round_word_type word_in_next;
   logic           filt;
   logic           feed;

   always_comb begin
      filt = filter_bit(word_in.state);
      if (init_mode) begin
         feed = word_in.aux[AUX_W-1] ^ key_bit ^ filt;
         word_in_next.aux = {word_in.aux[AUX_W-2:0], 1'b0};
      end else begin
         feed = parity_bit(word_in.state);
         word_in_next.aux = {word_in.aux[AUX_W-2:0], filt};
      end
      word_in_next.state = {word_in.state[STATE_W-2:0], feed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule

// ===== src/lfsr_filter_cipher_authenticator.sv =====
// A request word passes through every init cell, then every output cell,
// to its response word. Throughput: one word per cycle unless stalled; one
// cell per cipher round, 32 init and 32 output rounds, all cells advance
// together whenever the last holds no word or its word is taken.
// Reset clears every cell's valid flag and sets the key to zero.
module lfsr_filter_cipher_authenticator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_tag_id,
   input  logic [3:0]  req_button_code,
   input  logic [9:0]  req_control_word,
   input  logic [17:0] req_epoch_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_auth_word,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);
   import lfca_pkg::*;

   logic [STATE_W-1:0] key_ff;
   logic [STATE_W-1:0] key_in;
   logic               advance;
   round_word_type     head_word;
   round_word_type     cell_word [CELLS];
   logic [CELLS-1:0]   cell_valid;

   assign key_in = csr_wr_en ? csr_wr_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign advance   = !cell_valid[CELLS-1] || rsp_ready;
   assign req_ready = advance;

   assign head_word.state = {req_tag_id, key_ff[15:0]};
   assign head_word.aux   = {req_epoch_count, req_control_word, req_button_code};

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic           v_in;
      round_word_type w_in;
      logic           k_bit;

      if (i == 0) begin : g_head
         assign v_in = req_valid;
         assign w_in = head_word;
      end else begin : g_link
         assign v_in = cell_valid[i-1];
         assign w_in = cell_word[i-1];
      end

      if (i < ROUNDS) begin : g_init
         assign k_bit = key_ff[STATE_W-1-i];
      end else begin : g_out
         assign k_bit = 1'b0;
      end

      lfca_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .init_mode (i < ROUNDS),
         .key_bit   (k_bit),
         .valid_in  (v_in),
         .word_in   (w_in),
         .valid_out (cell_valid[i]),
         .word_out  (cell_word[i])
      );
   end

   assign rsp_valid     = cell_valid[CELLS-1];
   assign rsp_auth_word = cell_word[CELLS-1].aux;

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cell_valid[0])
      else $error("accepted word did not enter first cell");

   a_chain_moves: assert property (@(posedge clock) disable iff (reset)
      advance && cell_valid[CELLS-2] |=> cell_valid[CELLS-1])
      else $error("word lost between last two cells");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cell_valid))
      else $error("cell chain moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> cell_valid == '0)
      else $error("cells not empty after reset");
`endif

endmodule

// ===== tb/lfca_auth_checker.sv =====
`timescale 1ns / 1ps
module lfca_auth_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_tag_id,
   input  logic [3:0]  req_button_code,
   input  logic [9:0]  req_control_word,
   input  logic [17:0] req_epoch_count,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_auth_word,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   output int          fail_count,
   output int          pending_words,
   output int          checked_words
);

   localparam logic [15:0] NLF_EDGE  = 16'h2C79;
   localparam logic [15:0] NLF_INNER = 16'h6671;
   localparam logic [31:0] NLF_FINAL = 32'h7907287B;
   localparam logic [47:0] LFSR_TAPS = 48'hB380_8322_0073;

   logic [47:0] key_copy = '0;
   logic [31:0] auth_fifo[$];
   logic [31:0] expected_auth;

   function automatic logic lut4(input logic [15:0] tbl, input logic a, input logic b,
                                 input logic c, input logic d);
      logic [3:0] idx;
      idx = {a, b, c, d};
      return tbl[idx];
   endfunction

   function automatic logic nonlinear_bit(input logic [47:0] s);
      logic [4:0] sel;
      sel[0] = lut4(NLF_EDGE,  s[41], s[42], s[44], s[45]);
      sel[1] = lut4(NLF_INNER, s[32], s[33], s[35], s[39]);
      sel[2] = lut4(NLF_INNER, s[21], s[24], s[26], s[30]);
      sel[3] = lut4(NLF_INNER, s[14], s[16], s[18], s[19]);
      sel[4] = lut4(NLF_EDGE,  s[1],  s[3],  s[4],  s[13]);
      return NLF_FINAL[sel];
   endfunction

   function automatic logic [31:0] predict_auth(input logic [31:0] tag,
                                                input logic [3:0]  button,
                                                input logic [9:0]  control,
                                                input logic [17:0] epoch,
                                                input logic [47:0] key);
      logic [47:0] s;
      logic [31:0] iv;
      logic [31:0] auth;
      logic        fb;
      iv   = {epoch, control, button};
      s    = {tag, key[15:0]};
      auth = '0;
      for (int i = 0; i < 32; i++) begin
         fb = iv[31-i] ^ key[47-i] ^ nonlinear_bit(s);
         s  = {s[46:0], fb};
      end
      for (int i = 0; i < 32; i++) begin
         auth = {auth[30:0], nonlinear_bit(s)};
         s    = {s[46:0], ^(s & LFSR_TAPS)};
      end
      return auth;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_copy = '0;
         auth_fifo.delete();
         pending_words <= 0;
         fail_count    <= 0;
         checked_words <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (auth_fifo.size() == 0) begin
               $error("auth_word: expected none, actual %h", rsp_auth_word);
               fail_count <= fail_count + 1;
            end else begin
               expected_auth = auth_fifo.pop_front();
               checked_words <= checked_words + 1;
               if (expected_auth !== rsp_auth_word) begin
                  $error("auth_word: expected %h, actual %h", expected_auth, rsp_auth_word);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            auth_fifo.push_back(predict_auth(req_tag_id, req_button_code, req_control_word,
                                             req_epoch_count, key_copy));
         if (csr_wr_en)
            key_copy = csr_wr_data;
         pending_words <= auth_fifo.size();
      end
   end

endmodule

// ===== tb/lfsr_filter_cipher_authenticator_tb.sv =====
`timescale 1ns / 1ps
module lfsr_filter_cipher_authenticator_tb;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [31:0] req_tag_id       = '0;
   logic [3:0]  req_button_code  = '0;
   logic [9:0]  req_control_word = '0;
   logic [17:0] req_epoch_count  = '0;
   logic        rsp_ready        = 1'b0;
   logic        csr_wr_en        = 1'b0;
   logic [47:0] csr_wr_data      = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_auth_word;

   int fail_count;
   int pending_words;
   int checked_words;
   bit steady     = 1'b0;
   int words_sent = 0;
   int key_loads  = 0;

   lfsr_filter_cipher_authenticator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tag_id       (req_tag_id),
      .req_button_code  (req_button_code),
      .req_control_word (req_control_word),
      .req_epoch_count  (req_epoch_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_auth_word    (rsp_auth_word),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   lfca_auth_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tag_id       (req_tag_id),
      .req_button_code  (req_button_code),
      .req_control_word (req_control_word),
      .req_epoch_count  (req_epoch_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_auth_word    (rsp_auth_word),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words),
      .checked_words    (checked_words)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic send_word(input logic [31:0] tag, input logic [3:0] button,
                            input logic [9:0] control, input logic [17:0] epoch);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_tag_id       <= tag;
      req_button_code  <= button;
      req_control_word <= control;
      req_epoch_count  <= epoch;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
   endtask

   task automatic send_directed();
      send_word('0, '0, '0, '0);
      send_word('1, '1, '1, '1);
      send_word(32'hAAAA_AAAA, 4'h5, 10'h2AA, 18'h2_AAAA);
      send_word(32'h5555_5555, 4'hA, 10'h155, 18'h1_5555);
      send_word(32'h8000_0000, 4'h8, 10'h200, 18'h2_0000);
      send_word(32'h0000_0001, 4'h1, 10'h001, 18'h0_0001);
      send_word('1, '0, '0, '0);
      send_word('0, '1, '0, '0);
      send_word('0, '0, '1, '0);
      send_word('0, '0, '0, '1);
      send_word(32'hDEAD_BEEF, 4'h3, 10'h0F0, 18'h3_C00F);
      send_word(32'h0123_4567, 4'hC, 10'h30F, 18'h0_FF00);
      req_valid <= 1'b0;
   endtask

   task automatic send_random();
      logic [31:0] tag;
      logic [3:0]  button;
      logic [9:0]  control;
      logic [17:0] epoch;
      tag     = $urandom();
      button  = 4'($urandom_range(0, 15));
      control = 10'($urandom_range(0, 1023));
      epoch   = 18'($urandom_range(0, 262143));
      if ($urandom_range(0, 15) == 0) tag     = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 15) == 0) control = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 15) == 0) epoch   = $urandom_range(0, 1) ? '1 : '0;
      send_word(tag, button, control, epoch);
   endtask

   task automatic load_key(input logic [47:0] value);
      do @(negedge clock); while (pending_words != 0);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      key_loads++;
   endtask

   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      logic [47:0] phase_key;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      load_key('1);
      send_directed();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_key = '0;
            1: phase_key = 48'h8000_0000_0001;
            2: phase_key = '1;
            3: phase_key = 48'h5A5A_A5A5_0000;
            default: begin
               phase_key[47:32] = 16'($urandom_range(0, 16'hFFFF));
               phase_key[31:0]  = $urandom();
            end
         endcase
         load_key(phase_key);
         steady = (p % 3 == 1);
         repeat (155) send_random();
         req_valid <= 1'b0;
      end

      do @(negedge clock); while (pending_words != 0);
      repeat (80) @(negedge clock);
      $display("Drove %0d request words across %0d key loads, field extremes plus random.",
               words_sent, key_loads);
      $display("Compared %0d authenticator words in order against the predicted stream.",
               checked_words);
      if (fail_count == 0 && pending_words == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== lfsr_filter_cipher_authenticator.f =====
src/lfca_pkg.sv
src/lfca_cell.sv
src/lfsr_filter_cipher_authenticator.sv
tb/lfca_auth_checker.sv
tb/lfsr_filter_cipher_authenticator_tb.sv
